// File: design/sba_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the snooping bus arbiter.
// No dependencies; used by sba_emitter and snoop_bus_arbiter.
package sba_pkg;

  localparam int ADDR_W = 64;

  // Input opcodes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_REQ  = 2'd1;
  localparam logic [1:0] OP_MDR  = 2'd2;

  // Bus request types that the controller interprets
  localparam logic [2:0] T_DATA   = 3'd3;
  localparam logic [2:0] T_SHARED = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_SNOOP_WAIT = 2'd0;
  localparam logic [1:0] CFG_XFER_DELAY = 2'd1;
  localparam logic [1:0] CFG_ACT_PROCS  = 2'd2;

  typedef enum logic [1:0] {
    KIND_MEM_REQ  = 2'd0,
    KIND_SNOOP    = 2'd1,
    KIND_COMPLETE = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_WAIT_CACHE = 2'd0,
    PH_WAIT_MEM   = 2'd1,
    PH_XFER_CACHE = 2'd2,
    PH_XFER_MEM   = 2'd3
  } phase_t;

  // One registered input request
  typedef struct packed {
    logic [1:0]        opcode;
    logic [2:0]        rtype;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        proc;
    logic [7:0]        sharers;
    logic [15:0]       latency;
  } in_item_t;

  // Result group handed to the emitter: one head result plus snoop mask
  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [2:0]        rtype;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        proc;
    logic              xfer;
    logic [7:0]        snoops;
  } emit_load_t;

  // Queued request entry
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [2:0]        rtype;
  } q_entry_t;

endpackage

// File: design/sba_emitter.sv
`timescale 1ns / 1ps
// Result stage: holds one result group and sends it out one result per cycle while out_ready is high.
// Depends on sba_pkg (emit_load_t, kind_t).
module sba_emitter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sba_pkg::emit_load_t          load,
  output logic                         free,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_result_kind,
  output logic [2:0]                   out_type,
  output logic [sba_pkg::ADDR_W-1:0]   out_addr,
  output logic [2:0]                   out_proc,
  output logic                         out_was_cache_transfer,
  output logic                         out_last
);

  logic                       head_r;
  logic [7:0]                 mask_r;
  sba_pkg::kind_t             kind_r;
  logic [2:0]                 type_r;
  logic [sba_pkg::ADDR_W-1:0] addr_r;
  logic [2:0]                 proc_r;
  logic                       xfer_r;

  logic [7:0] low_bit;
  logic [7:0] mask_rest;
  logic [2:0] snoop_proc;
  logic       fire;

  // Lowest pending snoop target
  assign low_bit   = mask_r & (~mask_r + 8'd1);
  assign mask_rest = mask_r & ~low_bit;

  always_comb begin
    snoop_proc = '0;
    for (int i = 0; i < 8; i++) begin
      if (low_bit[i]) snoop_proc = 3'(i);
    end
  end

  // Head result first, then snoops in rising processor order
  always_comb begin
    out_valid = head_r || (mask_r != '0);
    out_type  = type_r;
    out_addr  = addr_r;
    if (head_r) begin
      out_result_kind        = kind_r;
      out_proc               = proc_r;
      out_was_cache_transfer = xfer_r;
      out_last               = (mask_r == '0);
    end else begin
      out_result_kind        = sba_pkg::KIND_SNOOP;
      out_proc               = snoop_proc;
      out_was_cache_transfer = 1'b0;
      out_last               = (mask_rest == '0);
    end
  end

  assign fire = out_valid && out_ready;
  assign free = !out_valid || (out_ready && out_last);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      mask_r <= '0;
    end else if (free && load.valid) begin
      head_r <= 1'b1;
      mask_r <= load.snoops;
    end else if (fire) begin
      if (head_r) begin
        head_r <= 1'b0;
      end else begin
        mask_r <= mask_rest;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (free && load.valid) begin
      kind_r <= load.kind;
      type_r <= load.rtype;
      addr_r <= load.addr;
      proc_r <= load.proc;
      xfer_r <= load.xfer;
    end
  end

endmodule

// File: design/snoop_bus_arbiter.sv
`timescale 1ns / 1ps
// Snooping bus controller with round-robin arbitration over per-processor queues.
// Flow: a request is registered in the input register at accept and decoded from there once
// the result stage is free; its results are registered in the result stage before they are presented.
// Throughput: one request per cycle while each gives at most one result and out_ready is high; a request
// with k results (memory request plus snoops, up to 9) occupies the result stage until its last is taken.
// Reset (rst_n low, synchronous): bus idle, queues empty, both delay registers = 10,
// active_procs = 1; queue storage is not cleared.
module snoop_bus_arbiter #(
  parameter int PROCS       = 8,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_opcode,
  input  logic [2:0]                 in_req_type,
  input  logic [sba_pkg::ADDR_W-1:0] in_line_addr,
  input  logic [2:0]                 in_proc_id,
  input  logic [7:0]                 in_sharer_mask,
  input  logic [15:0]                in_mem_latency,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_result_kind,
  output logic [2:0]                 out_type,
  output logic [sba_pkg::ADDR_W-1:0] out_addr,
  output logic [2:0]                 out_proc,
  output logic                       out_was_cache_transfer,
  output logic                       out_last,
  // configuration channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [15:0]                cfg_data
);

  localparam int PW  = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW  = QCW + 1;
  localparam logic [4:0]   PROCS_L = 5'(PROCS);
  localparam logic [SW-1:0] QD_S   = SW'(QUEUE_DEPTH);

  // Configuration registers
  logic [15:0] snoop_wait_r;
  logic [15:0] xfer_delay_r;
  logic [3:0]  act_procs_r;

  // Input register
  logic              in_v_r;
  sba_pkg::in_item_t in_r;
  logic              go;
  logic              em_free;

  // Bus state
  logic                       pend_valid_r, pend_valid_nxt;
  logic [2:0]                 pend_type_r, pend_type_nxt;
  logic [sba_pkg::ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [2:0]                 pend_proc_r, pend_proc_nxt;
  sba_pkg::phase_t            phase_r, phase_nxt;
  logic                       shared_r, shared_nxt;
  logic                       data_r, data_nxt;
  logic                       data_ready_r, data_ready_nxt;
  logic [15:0]                countdown_r, countdown_nxt;
  logic [PW-1:0]              next_rr_r, next_rr_nxt;
  logic [QCW-1:0]             q_count_r [PROCS];
  logic [QCW-1:0]             q_count_nxt [PROCS];
  logic [QIW-1:0]             q_head_r [PROCS];
  logic [QIW-1:0]             q_head_nxt [PROCS];

  // Queue storage
  sba_pkg::q_entry_t q_mem [PROCS][QUEUE_DEPTH];
  logic              enq_we;
  logic [PW-1:0]     enq_proc;
  logic [QIW-1:0]    enq_slot;
  sba_pkg::q_entry_t enq_entry;

  sba_pkg::emit_load_t load;

  // Effective processor count
  logic [4:0] ap_ext;
  logic [4:0] np;
  logic [7:0] proc_mask;

  assign ap_ext = {1'b0, act_procs_r};
  assign np     = (ap_ext == '0) ? 5'd1 : ((ap_ext > PROCS_L) ? PROCS_L : ap_ext);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      proc_mask[i] = (5'(i) < np);
    end
  end

  // Round-robin start: next_rr folded below np by shift-and-subtract
  logic [8:0] rr_fold;
  logic [4:0] rr_start;

  always_comb begin
    rr_fold = 9'(next_rr_r);
    for (int k = PW - 1; k >= 0; k--) begin
      if (rr_fold >= (9'(np) << k)) rr_fold = rr_fold - (9'(np) << k);
    end
  end
  assign rr_start = rr_fold[4:0];

  // First non-empty queue at or after the start position
  logic          rr_found;
  logic [PW-1:0] rr_sel;
  logic [5:0]    rr_cand [PROCS];

  always_comb begin
    rr_found = 1'b0;
    rr_sel   = '0;
    for (int i = 0; i < PROCS; i++) begin
      rr_cand[i] = 6'(rr_start) + 6'(i);
      if (rr_cand[i] >= 6'(np)) rr_cand[i] = rr_cand[i] - 6'(np);
      if (!rr_found && (6'(i) < 6'(np)) && (q_count_r[rr_cand[i][PW-1:0]] != '0)) begin
        rr_found = 1'b1;
        rr_sel   = rr_cand[i][PW-1:0];
      end
    end
  end

  logic [5:0]     rr_inc;
  logic [QIW:0]   deq_head_inc;
  sba_pkg::q_entry_t deq_entry;

  assign rr_inc       = 6'(rr_sel) + 6'd1;
  assign deq_head_inc = (QIW + 1)'(q_head_r[rr_sel]) + (QIW + 1)'(1);
  assign deq_entry    = q_mem[rr_sel][q_head_r[rr_sel]];

  // Tick countdown step
  logic [15:0]     tick_cd;
  sba_pkg::phase_t tick_ph;

  assign tick_cd = data_ready_r ? 16'd0 :
                   ((countdown_r != '0) ? (countdown_r - 16'd1) : 16'd0);
  assign tick_ph = data_ready_r ? sba_pkg::PH_XFER_MEM : phase_r;

  // Request side: queue index and tail slot
  logic          req_proc_ok;
  logic [PW-1:0] req_idx;
  logic          req_full;
  logic [SW-1:0] tail_sum;
  logic [SW-1:0] tail_slot;
  logic          addr_hit;

  assign req_proc_ok = ({2'b00, in_r.proc} < PROCS_L);
  assign req_idx     = PW'(in_r.proc);
  assign req_full    = !req_proc_ok || (q_count_r[req_idx] >= QCW'(QUEUE_DEPTH));
  assign tail_sum    = SW'(q_head_r[req_idx]) + SW'(q_count_r[req_idx]);
  assign tail_slot   = (tail_sum >= QD_S) ? (tail_sum - QD_S) : tail_sum;
  assign addr_hit    = (pend_addr_r == in_r.addr);

  // Next bus state and result group
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_type_nxt  = pend_type_r;
    pend_addr_nxt  = pend_addr_r;
    pend_proc_nxt  = pend_proc_r;
    phase_nxt      = phase_r;
    shared_nxt     = shared_r;
    data_nxt       = data_r;
    data_ready_nxt = data_ready_r;
    countdown_nxt  = countdown_r;
    next_rr_nxt    = next_rr_r;
    q_count_nxt    = q_count_r;
    q_head_nxt     = q_head_r;
    enq_we         = 1'b0;
    enq_proc       = req_idx;
    enq_slot       = tail_slot[QIW-1:0];
    enq_entry      = '{addr: in_r.addr, rtype: in_r.rtype};
    load           = '0;
    load.addr      = pend_addr_r;
    load.proc      = pend_proc_r;
    load.rtype     = pend_type_r;

    if (go) begin
      case (in_r.opcode)
        sba_pkg::OP_TICK: begin
          if (pend_valid_r) begin
            countdown_nxt = tick_cd;
            phase_nxt     = tick_ph;
            if (tick_cd == '0) begin
              case (tick_ph)
                sba_pkg::PH_WAIT_CACHE: begin
                  load.valid    = 1'b1;
                  load.kind     = sba_pkg::KIND_MEM_REQ;
                  load.snoops   = in_r.sharers & proc_mask;
                  countdown_nxt = in_r.latency;
                  phase_nxt     = sba_pkg::PH_WAIT_MEM;
                  if (data_r) pend_type_nxt = sba_pkg::T_DATA;
                end
                sba_pkg::PH_XFER_CACHE: begin
                  load.valid     = 1'b1;
                  load.kind      = sba_pkg::KIND_COMPLETE;
                  load.rtype     = shared_r ? sba_pkg::T_SHARED : pend_type_r;
                  load.xfer      = 1'b1;
                  pend_valid_nxt = 1'b0;
                end
                sba_pkg::PH_XFER_MEM: begin
                  load.valid     = 1'b1;
                  load.kind      = sba_pkg::KIND_COMPLETE;
                  load.rtype     = shared_r ? sba_pkg::T_SHARED : sba_pkg::T_DATA;
                  pend_valid_nxt = 1'b0;
                end
                default: ;  // waiting memory: hold until the data arrives
              endcase
            end
          end else if (rr_found) begin
            // Move the next queued request onto the bus
            pend_valid_nxt      = 1'b1;
            pend_type_nxt       = deq_entry.rtype;
            pend_addr_nxt       = deq_entry.addr;
            pend_proc_nxt       = 3'(rr_sel);
            phase_nxt           = sba_pkg::PH_WAIT_CACHE;
            shared_nxt          = 1'b0;
            data_nxt            = 1'b0;
            data_ready_nxt      = 1'b0;
            countdown_nxt       = snoop_wait_r;
            q_head_nxt[rr_sel]  = (deq_head_inc == (QIW + 1)'(QUEUE_DEPTH)) ?
                                  '0 : deq_head_inc[QIW-1:0];
            q_count_nxt[rr_sel] = q_count_r[rr_sel] - QCW'(1);
            next_rr_nxt         = (rr_inc == 6'(np)) ? '0 : rr_inc[PW-1:0];
          end
        end
        sba_pkg::OP_REQ: begin
          if (!pend_valid_r) begin
            if (in_r.rtype != sba_pkg::T_SHARED) begin
              pend_valid_nxt = 1'b1;
              pend_type_nxt  = in_r.rtype;
              pend_addr_nxt  = in_r.addr;
              pend_proc_nxt  = in_r.proc;
              phase_nxt      = sba_pkg::PH_WAIT_CACHE;
              shared_nxt     = 1'b0;
              data_nxt       = 1'b0;
              data_ready_nxt = 1'b0;
              countdown_nxt  = snoop_wait_r;
            end
          end else if (in_r.rtype == sba_pkg::T_SHARED) begin
            if (addr_hit) shared_nxt = 1'b1;
          end else if (in_r.rtype == sba_pkg::T_DATA && addr_hit) begin
            // Cache supplies the line: switch to a cache-to-cache transfer
            if (phase_r == sba_pkg::PH_WAIT_MEM) begin
              data_nxt      = 1'b1;
              phase_nxt     = sba_pkg::PH_XFER_CACHE;
              countdown_nxt = xfer_delay_r;
            end
          end else if (req_full) begin
            load.valid = 1'b1;
            load.kind  = sba_pkg::KIND_OVERFLOW;
            load.rtype = in_r.rtype;
            load.addr  = in_r.addr;
            load.proc  = in_r.proc;
          end else begin
            enq_we               = 1'b1;
            q_count_nxt[req_idx] = q_count_r[req_idx] + QCW'(1);
          end
        end
        sba_pkg::OP_MDR: begin
          if (pend_valid_r && addr_hit && (pend_proc_r == in_r.proc)) data_ready_nxt = 1'b1;
        end
        default: ;  // unused opcode
      endcase
    end
  end

  // Handshakes
  assign go        = in_v_r && em_free;
  assign in_ready  = !in_v_r || go;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= '{opcode: in_opcode, rtype: in_req_type, addr: in_line_addr,
                proc: in_proc_id, sharers: in_sharer_mask, latency: in_mem_latency};
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snoop_wait_r <= 16'd10;
      xfer_delay_r <= 16'd10;
      act_procs_r  <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sba_pkg::CFG_SNOOP_WAIT: snoop_wait_r <= cfg_data;
        sba_pkg::CFG_XFER_DELAY: xfer_delay_r <= cfg_data;
        sba_pkg::CFG_ACT_PROCS:  act_procs_r  <= cfg_data[3:0];
        default: ;  // no register at this index
      endcase
    end
  end

  // Bus and queue control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      pend_type_r  <= '0;
      pend_addr_r  <= '0;
      pend_proc_r  <= '0;
      phase_r      <= sba_pkg::PH_WAIT_CACHE;
      shared_r     <= 1'b0;
      data_r       <= 1'b0;
      data_ready_r <= 1'b0;
      countdown_r  <= '0;
      next_rr_r    <= '0;
      for (int p = 0; p < PROCS; p++) begin
        q_count_r[p] <= '0;
        q_head_r[p]  <= '0;
      end
    end else begin
      pend_valid_r <= pend_valid_nxt;
      pend_type_r  <= pend_type_nxt;
      pend_addr_r  <= pend_addr_nxt;
      pend_proc_r  <= pend_proc_nxt;
      phase_r      <= phase_nxt;
      shared_r     <= shared_nxt;
      data_r       <= data_nxt;
      data_ready_r <= data_ready_nxt;
      countdown_r  <= countdown_nxt;
      next_rr_r    <= next_rr_nxt;
      q_count_r    <= q_count_nxt;
      q_head_r     <= q_head_nxt;
    end
  end

  // Queue storage write
  always_ff @(posedge clk) begin
    if (enq_we) q_mem[enq_proc][enq_slot] <= enq_entry;
  end

  sba_emitter u_emitter (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .load                   (load),
    .free                   (em_free),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_result_kind        (out_result_kind),
    .out_type               (out_type),
    .out_addr               (out_addr),
    .out_proc               (out_proc),
    .out_was_cache_transfer (out_was_cache_transfer),
    .out_last               (out_last)
  );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for snoop_bus_arbiter: a predictor of the bus controller
// drives expected results that are checked field by field. Depends on sba_pkg.
module testbench;

  localparam int PROCS_N         = 8;
  localparam int QDEPTH          = 4;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int SETTLE_CYCLES   = 8;
  localparam int STALL_LIMIT     = 3000;

  // Opcode and register index the block must ignore
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // Register settings per phase, extremes included
  localparam logic [15:0] CACHE_WAIT_SET [PHASES] = '{0, 2, 65535, 1, 4, 0, 3, 10};
  localparam logic [15:0] XFER_WAIT_SET  [PHASES] = '{0, 1, 65535, 3, 2, 5, 0, 10};
  localparam logic [15:0] PROCS_SET      [PHASES] = '{8, 3, 8, 0, 15, 5, 2, 8};

  typedef struct packed {
    sba_pkg::kind_t kind;
    logic [2:0]     rtype;
    logic [63:0]    addr;
    logic [2:0]     proc;
    logic           xfer;
    logic           last;
  } bus_action_t;

  // Bus controller predictor plus the list of bus actions still owed by the block
  class bus_scoreboard;
    bit [15:0]       cache_wait;
    bit [15:0]       xfer_wait;
    bit [3:0]        procs_reg;
    bit              busy;
    bit [2:0]        cur_type;
    bit [63:0]       cur_addr;
    bit [2:0]        cur_proc;
    sba_pkg::phase_t cur_phase;
    bit              cur_shared;
    bit              cur_data;
    bit              mem_ready;
    bit [15:0]       countdown;
    int unsigned     rr_next;
    bit [63:0]       fifo_addr [PROCS_N][QDEPTH];
    bit [2:0]        fifo_type [PROCS_N][QDEPTH];
    int unsigned     fifo_cnt [PROCS_N];
    int unsigned     fifo_head [PROCS_N];
    bus_action_t     actions_due[$];
    bus_action_t     batch[$];
    int              errors;

    function new();
      cache_wait = 16'd10;
      xfer_wait  = 16'd10;
      procs_reg  = 4'd1;
      busy       = 1'b0;
      cur_phase  = sba_pkg::PH_WAIT_CACHE;
      countdown  = '0;
      rr_next    = 0;
      errors     = 0;
      foreach (fifo_cnt[i]) begin
        fifo_cnt[i]  = 0;
        fifo_head[i] = 0;
      end
    endfunction

    function void apply_register(logic [1:0] idx, logic [15:0] val);
      case (idx)
        sba_pkg::CFG_SNOOP_WAIT: cache_wait = val;
        sba_pkg::CFG_XFER_DELAY: xfer_wait = val;
        sba_pkg::CFG_ACT_PROCS:  procs_reg = val[3:0];
        default: ;
      endcase
    endfunction

    function void add_action(sba_pkg::kind_t k, bit [2:0] t, bit [63:0] a, bit [2:0] p,
                             bit x);
      bus_action_t act;
      act.kind  = k;
      act.rtype = t;
      act.addr  = a;
      act.proc  = p;
      act.xfer  = x;
      act.last  = 1'b0;
      batch.insert(batch.size(), act);
    endfunction

    function void begin_request(bit [2:0] t, bit [63:0] a, bit [2:0] p);
      busy       = 1'b1;
      cur_type   = t;
      cur_addr   = a;
      cur_proc   = p;
      cur_phase  = sba_pkg::PH_WAIT_CACHE;
      cur_shared = 1'b0;
      cur_data   = 1'b0;
      mem_ready  = 1'b0;
      countdown  = cache_wait;
    endfunction

    // Advance the bus by one accepted request and queue the actions it causes
    function void note_request(sba_pkg::in_item_t it);
      int unsigned np;
      int unsigned pos;
      int unsigned slot;
      bus_action_t act;
      batch.delete();
      np = (procs_reg == 0) ? 1 : ((procs_reg > PROCS_N) ? PROCS_N : procs_reg);
      case (it.opcode)
        sba_pkg::OP_TICK: begin
          if (busy) begin
            if (countdown != 0) countdown--;
            // memory data short-circuits any wait
            if (mem_ready) begin
              cur_phase = sba_pkg::PH_XFER_MEM;
              countdown = '0;
            end
            if (countdown == 0) begin
              case (cur_phase)
                sba_pkg::PH_WAIT_CACHE: begin
                  add_action(sba_pkg::KIND_MEM_REQ, cur_type, cur_addr, cur_proc, 1'b0);
                  countdown = it.latency;
                  cur_phase = sba_pkg::PH_WAIT_MEM;
                  for (int i = 0; i < np; i++)
                    if (it.sharers[i])
                      add_action(sba_pkg::KIND_SNOOP, cur_type, cur_addr, 3'(i), 1'b0);
                  if (cur_data) cur_type = sba_pkg::T_DATA;
                end
                sba_pkg::PH_XFER_MEM: begin
                  add_action(sba_pkg::KIND_COMPLETE,
                             cur_shared ? sba_pkg::T_SHARED : sba_pkg::T_DATA, cur_addr,
                             cur_proc, 1'b0);
                  busy = 1'b0;
                end
                sba_pkg::PH_XFER_CACHE: begin
                  add_action(sba_pkg::KIND_COMPLETE,
                             cur_shared ? sba_pkg::T_SHARED : cur_type, cur_addr,
                             cur_proc, 1'b1);
                  busy = 1'b0;
                end
                default: ;
              endcase
            end
          end else begin
            // round-robin pick among the queues in use
            for (int i = 0; i < np; i++) begin
              pos = (i + rr_next) % np;
              if (fifo_cnt[pos] != 0) begin
                begin_request(fifo_type[pos][fifo_head[pos]], fifo_addr[pos][fifo_head[pos]],
                              3'(pos));
                fifo_head[pos] = (fifo_head[pos] + 1) % QDEPTH;
                fifo_cnt[pos]--;
                rr_next = (pos + 1) % np;
                break;
              end
            end
          end
        end
        sba_pkg::OP_REQ: begin
          if (!busy) begin
            if (it.rtype != sba_pkg::T_SHARED) begin_request(it.rtype, it.addr, it.proc);
          end else if (it.rtype == sba_pkg::T_SHARED) begin
            if (it.addr == cur_addr) cur_shared = 1'b1;
          end else if (it.rtype == sba_pkg::T_DATA && it.addr == cur_addr) begin
            if (cur_phase == sba_pkg::PH_WAIT_MEM) begin
              cur_data  = 1'b1;
              cur_phase = sba_pkg::PH_XFER_CACHE;
              countdown = xfer_wait;
            end
          end else if (fifo_cnt[it.proc] >= QDEPTH) begin
            add_action(sba_pkg::KIND_OVERFLOW, it.rtype, it.addr, it.proc, 1'b0);
          end else begin
            slot = (fifo_head[it.proc] + fifo_cnt[it.proc]) % QDEPTH;
            fifo_addr[it.proc][slot] = it.addr;
            fifo_type[it.proc][slot] = it.rtype;
            fifo_cnt[it.proc]++;
          end
        end
        sba_pkg::OP_MDR: begin
          if (busy && it.addr == cur_addr && it.proc == cur_proc) mem_ready = 1'b1;
        end
        default: ;
      endcase
      // the final action of a request carries last
      foreach (batch[i]) begin
        act      = batch[i];
        act.last = (i == batch.size() - 1);
        actions_due.insert(actions_due.size(), act);
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_action(logic [1:0] k, logic [2:0] t, logic [63:0] a, logic [2:0] p,
                               logic x, logic l);
      bus_action_t want;
      if (actions_due.size() == 0) begin
        $error("unexpected result: kind %0d addr %0h proc %0d", k, a, p);
        errors++;
        return;
      end
      want = actions_due.pop_front();
      compare_field("result_kind", want.kind, k);
      compare_field("out_type", want.rtype, t);
      compare_field("out_addr", want.addr, a);
      compare_field("out_proc", want.proc, p);
      compare_field("was_cache_transfer", want.xfer, x);
      compare_field("last", want.last, l);
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              out_ready = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [15:0]       cfg_data  = '0;
  sba_pkg::in_item_t req_item  = '0;
  wire         in_ready;
  wire         out_valid;
  wire         cfg_ready;
  wire [1:0]   in_opcode      = req_item.opcode;
  wire [2:0]   in_req_type    = req_item.rtype;
  wire [63:0]  in_line_addr   = req_item.addr;
  wire [2:0]   in_proc_id     = req_item.proc;
  wire [7:0]   in_sharer_mask = req_item.sharers;
  wire [15:0]  in_mem_latency = req_item.latency;
  wire [1:0]   out_result_kind;
  wire [2:0]   out_type;
  wire [63:0]  out_addr;
  wire [2:0]   out_proc;
  wire         out_was_cache_transfer;
  wire         out_last;

  bus_scoreboard sb;
  int          idle_pct  = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;
  logic [63:0] addr_pool [6];

  snoop_bus_arbiter dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_opcode, .in_req_type, .in_line_addr, .in_proc_id,
    .in_sharer_mask, .in_mem_latency,
    .out_valid, .out_ready, .out_result_kind, .out_type, .out_addr, .out_proc,
    .out_was_cache_transfer, .out_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #5ns clk = ~clk;

  // Result receiver: random back-pressure
  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= stall_pct);

  // Observe accepted requests, results and register writes
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.apply_register(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_request(req_item);
      if (out_valid === 1'b1 && out_ready)
        sb.check_action(out_result_kind, out_type, out_addr, out_proc,
                        out_was_cache_transfer, out_last);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic sba_pkg::in_item_t bus_item(logic [1:0] op, logic [2:0] t,
                                                 logic [63:0] a, logic [2:0] p,
                                                 logic [7:0] m, logic [15:0] lat);
    sba_pkg::in_item_t it;
    it.opcode  = op;
    it.rtype   = t;
    it.addr    = a;
    it.proc    = p;
    it.sharers = m;
    it.latency = lat;
    return it;
  endfunction

  // Mostly a small set of lines so addresses collide, sometimes any address
  function automatic logic [63:0] pick_addr();
    if ($urandom_range(0, 99) < 25) return {$urandom, $urandom};
    return addr_pool[$urandom_range(0, 5)];
  endfunction

  // Random request shaped by the bus state, with some pure noise mixed in
  function automatic sba_pkg::in_item_t random_item();
    sba_pkg::in_item_t it;
    int unsigned       pick;
    int unsigned       waiting;
    bit                noise;
    it.opcode  = sba_pkg::OP_TICK;
    it.rtype   = 3'($urandom_range(0, 7));
    it.addr    = pick_addr();
    it.proc    = 3'($urandom_range(0, 7));
    it.sharers = 8'($urandom);
    it.latency = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 6)) : 16'($urandom);
    waiting = 0;
    foreach (sb.fifo_cnt[i]) waiting += sb.fifo_cnt[i];
    noise = 1'b0;
    pick  = $urandom_range(0, 99);
    if (sb.busy) begin
      if (pick < 40) begin
        it.opcode = sba_pkg::OP_TICK;
      end else if (pick < 58) begin
        it.opcode = sba_pkg::OP_REQ;
      end else if (pick < 65) begin
        it.opcode = sba_pkg::OP_REQ;
        it.rtype  = sba_pkg::T_SHARED;
        it.addr   = sb.cur_addr;
      end else if (pick < 73) begin
        it.opcode = sba_pkg::OP_REQ;
        it.rtype  = sba_pkg::T_DATA;
        it.addr   = sb.cur_addr;
      end else if (pick < 82) begin
        it.opcode = sba_pkg::OP_MDR;
        it.addr   = sb.cur_addr;
        it.proc   = sb.cur_proc;
      end else begin
        noise = 1'b1;
      end
    end else if (waiting != 0) begin
      if (pick < 55) it.opcode = sba_pkg::OP_TICK;
      else if (pick < 88) it.opcode = sba_pkg::OP_REQ;
      else noise = 1'b1;
    end else begin
      if (pick < 65) it.opcode = sba_pkg::OP_REQ;
      else if (pick < 85) it.opcode = sba_pkg::OP_TICK;
      else noise = 1'b1;
    end
    // stray opcode, stray memory data, or shared mark for some other line
    if (noise) begin
      case ($urandom_range(0, 2))
        0: it.opcode = OP_UNUSED;
        1: it.opcode = sba_pkg::OP_MDR;
        default: begin
          it.opcode = sba_pkg::OP_REQ;
          it.rtype  = sba_pkg::T_SHARED;
        end
      endcase
    end
    return it;
  endfunction

  // Present one request, with random idle cycles ahead of it
  task automatic send_request(input sba_pkg::in_item_t it);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(negedge clk);
    end
    req_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic set_register(input logic [1:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stop sending and wait for every owed result, then let the pipeline empty
  task automatic settle_bus();
    in_valid <= 1'b0;
    while (sb.actions_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    sba_pkg::in_item_t it;
    int unsigned       done_items;
    sb = new();
    foreach (addr_pool[i]) addr_pool[i] = {$urandom, $urandom};
    addr_pool[0] = '0;
    addr_pool[1] = '1;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: short waits, all processors snooped
    set_register(sba_pkg::CFG_SNOOP_WAIT, 16'd2);
    set_register(sba_pkg::CFG_XFER_DELAY, 16'd1);
    set_register(sba_pkg::CFG_ACT_PROCS, 16'd8);
    send_request(bus_item(OP_UNUSED, 3'd7, '1, 3'd7, 8'hFF, 16'hFFFF));
    send_request(bus_item(sba_pkg::OP_MDR, 3'd0, '1, 3'd3, 8'h00, 16'd0));
    send_request(bus_item(sba_pkg::OP_REQ, sba_pkg::T_SHARED, '1, 3'd2, 8'h00, 16'd0));
    send_request(bus_item(sba_pkg::OP_REQ, 3'd1, '0, 3'd0, 8'h00, 16'd0));
    send_request(bus_item(sba_pkg::OP_REQ, 3'd2, '1, 3'd1, 8'h00, 16'd0));
    send_request(bus_item(sba_pkg::OP_REQ, sba_pkg::T_SHARED, '1, 3'd4, 8'h00, 16'd0));
    send_request(bus_item(sba_pkg::OP_REQ, sba_pkg::T_SHARED, '0, 3'd5, 8'h00, 16'd0));
    send_request(bus_item(sba_pkg::OP_REQ, sba_pkg::T_DATA, '0, 3'd6, 8'h00, 16'd0));
    send_request(bus_item(sba_pkg::OP_TICK, 3'd0, '0, 3'd0, 8'h00, 16'd0));
    // memory request plus a snoop to every processor
    send_request(bus_item(sba_pkg::OP_TICK, 3'd0, '0, 3'd0, 8'hFF, 16'hFFFF));
    send_request(bus_item(sba_pkg::OP_REQ, sba_pkg::T_DATA, '0, 3'd3, 8'h00, 16'd0));
    send_request(bus_item(sba_pkg::OP_TICK, 3'd0, '0, 3'd0, 8'h00, 16'd0));
    send_request(bus_item(sba_pkg::OP_TICK, 3'd0, '0, 3'd0, 8'h00, 16'd0));
    send_request(bus_item(sba_pkg::OP_MDR, 3'd0, '1, 3'd0, 8'h00, 16'd0));
    send_request(bus_item(sba_pkg::OP_MDR, 3'd0, '1, 3'd1, 8'h00, 16'd0));
    send_request(bus_item(sba_pkg::OP_TICK, 3'd0, '0, 3'd0, 8'h00, 16'd0));
    send_request(bus_item(sba_pkg::OP_REQ, 3'd7, addr_pool[2], 3'd3, 8'h00, 16'd0));
    // fill one queue, then overflow it
    send_request(bus_item(sba_pkg::OP_REQ, 3'd0, '0, 3'd5, 8'h00, 16'd0));
    send_request(bus_item(sba_pkg::OP_REQ, 3'd5, '0, 3'd5, 8'h00, 16'd0));
    send_request(bus_item(sba_pkg::OP_REQ, 3'd6, '0, 3'd5, 8'h00, 16'd0));
    send_request(bus_item(sba_pkg::OP_REQ, 3'd2, '0, 3'd5, 8'h00, 16'd0));
    send_request(bus_item(sba_pkg::OP_REQ, 3'd1, '1, 3'd5, 8'h00, 16'd0));
    send_request(bus_item(sba_pkg::OP_TICK, 3'd0, '0, 3'd0, 8'h00, 16'd0));
    send_request(bus_item(sba_pkg::OP_TICK, 3'd0, '0, 3'd0, 8'h0F, 16'd0));

    // Random phases, each with its own register setting and idle pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      settle_bus();
      if (ph == PHASES - 1) set_register(CFG_UNUSED, 16'hA5A5);
      set_register(sba_pkg::CFG_SNOOP_WAIT, CACHE_WAIT_SET[ph]);
      set_register(sba_pkg::CFG_XFER_DELAY, XFER_WAIT_SET[ph]);
      set_register(sba_pkg::CFG_ACT_PROCS, PROCS_SET[ph]);
      idle_pct  = (ph % 4 == 1) ? 82 : ((ph % 4 == 3) ? 15 : 0);
      stall_pct = (ph % 4 == 2) ? 82 : ((ph % 4 == 3) ? 15 : 0);
      done_items = 0;
      while (done_items < ITEMS_PER_PHASE) begin
        it = random_item();
        send_request(it);
        done_items++;
      end
    end

    idle_pct  = 0;
    stall_pct = 0;
    settle_bus();
    if (sb.errors == 0 && sb.actions_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
